// ----- src/lcs_constant_value_iteration_macros.svh -----
// Assertion macros used by the LCS value-iteration checker.
`ifndef LCS_CONSTANT_VALUE_ITERATION_MACROS_SVH
`define LCS_CONSTANT_VALUE_ITERATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lcs_pkg.sv -----
// Package: types, constants and saturating arithmetic for the LCS value-iteration block.
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int STRING_LENGTH = 8;
  localparam int NB            = 2 * STRING_LENGTH;  // bits of a string pair
  localparam int ADDR_W        = NB - 1;              // vector entry address
  localparam int SUB_W         = 4;

  localparam logic [ADDR_W-1:0] IDX_LAST   = '1;
  localparam logic [32:0]       DEPTH_EXT  = 33'(1) << ADDR_W;
  localparam logic [NB-1:0]     ODD_M      = NB'(32'hAAAAAAAA);
  localparam logic [NB-1:0]     EVEN_M     = NB'(32'h55555555);
  localparam logic [NB-1:0]     LO_M       = NB'((33'(1) << (NB - 2)) - 33'(1));
  localparam logic [NB-1:0]     HI_M       = NB'((33'(1) << (NB - 1)) - 33'(1));

  localparam logic signed [63:0] FX_ONE = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN  = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ITER  = 2'd2
  } lcs_op_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_LIMIT   = 2'd1,
    STS_BAD_IDX = 2'd2
  } lcs_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_PASS1,
    ST_PREP,
    ST_PASS2,
    ST_FIN,
    ST_RESP
  } lcs_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [14:0]        entry_index;
    logic signed [63:0] entry_value;
  } lcs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] read_value;
    logic signed [63:0] growth_r;
    logic [62:0]        excess_e;
    logic [15:0]        iteration_number;
  } lcs_out_t;

  typedef struct packed {
    logic              cap_item;
    logic              clr_wr;
    logic              host_wr;
    logic              host_rd;
    logic              cap_rd;
    logic              run;
    logic              pass2;
    logic              start;
    logic              prep;
    logic              finish;
    logic              load_out;
    lcs_status_t       status;
    logic [ADDR_W-1:0] idx;
    logic [SUB_W-1:0]  sub;
  } lcs_cmd_t;

  typedef struct packed {
    lcs_op_t op;
    logic    idx_bad;
    logic    limit_hit;
  } lcs_sts_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S_MIN : S_MAX;
    return s[63:0];
  endfunction

endpackage

// ----- src/lcs_constant_value_iteration.sv -----
// Top level of the LCS-constant value-iteration engine.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one item per transfer (operation, entry_index, entry_value).
//           Write and read touch one entry of the current value vector;
//           iterate runs one full value-iteration step over all 2^(2L-1) entries.
//   out_* : exactly one result per item: status, read value, last growth R,
//           last excess E and the completed iteration count.
//   cfg_* : max_iterations; always ready, write only while the block is idle.
// Sequence: write and read go through EXEC to RESP (read via RDWAIT); iterate
//   runs PASS1, PREP, PASS2 and FIN. Every entry of each pass walks its sub-steps:
//   five reads through the single read port of the vector memories, then the
//   saturating add/compare steps. Throughput is one item at a time.
// Reset: the current vector is cleared by a sweep over all 2^(2L-1) entries,
//   during which in_stall stays high; cfg writes are taken.
// Stall: a finished result sits in the output register until its transfer;
//   the next item may be accepted meanwhile and its result waits behind it.
module lcs_constant_value_iteration (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcs_pkg::lcs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lcs_pkg::lcs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import lcs_pkg::*;

  lcs_cmd_t cmd;
  lcs_sts_t sts;

  // Configuration is a single register: always ready.
  assign cfg_ready = 1'b1;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ----- src/lcs_ctrl.sv -----
// Controller: sequences clear, host access and the two iteration passes.
`timescale 1ns / 1ps

module lcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  lcs_pkg::lcs_sts_t sts,
  output lcs_pkg::lcs_cmd_t cmd
);
  import lcs_pkg::*;

  localparam logic [SUB_W-1:0] LAST_SUB = SUB_W'(8);

  lcs_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [SUB_W-1:0]  sub_r, sub_nxt;
  lcs_status_t       status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      sub_r       <= '0;
      status_r    <= STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      sub_r       <= sub_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.sub       = sub_r;
    cmd.status    = status_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        idx_nxt    = idx_r + ADDR_W'(1);
        if (idx_r == IDX_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_nxt = STS_OK;
        state_nxt  = ST_RESP;
        case (sts.op)
          OP_WRITE: begin
            if (sts.idx_bad) status_nxt = STS_BAD_IDX;
            else cmd.host_wr = 1'b1;
          end
          OP_READ: begin
            if (sts.idx_bad) begin
              status_nxt = STS_BAD_IDX;
            end else begin
              cmd.host_rd = 1'b1;
              state_nxt   = ST_RDWAIT;
            end
          end
          OP_ITER: begin
            if (sts.limit_hit) begin
              status_nxt = STS_LIMIT;
            end else begin
              cmd.start = 1'b1;
              idx_nxt   = '0;
              sub_nxt   = '0;
              state_nxt = ST_PASS1;
            end
          end
          default: status_nxt = STS_OK;
        endcase
      end
      ST_RDWAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_PASS1, ST_PASS2: begin
        cmd.run   = 1'b1;
        cmd.pass2 = (state_r == ST_PASS2);
        if (sub_r == LAST_SUB) begin
          sub_nxt = '0;
          idx_nxt = idx_r + ADDR_W'(1);
          if (idx_r == IDX_LAST) state_nxt = (state_r == ST_PASS1) ? ST_PREP : ST_FIN;
        end else begin
          sub_nxt = sub_r + SUB_W'(1);
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_PASS2;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- src/lcs_dpath.sv -----
// Datapath: value vectors, gather address folding, saturating step arithmetic.
`timescale 1ns / 1ps

module lcs_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  input  lcs_pkg::lcs_in_t  in_data,
  input  lcs_pkg::lcs_cmd_t cmd,
  output lcs_pkg::lcs_sts_t sts,
  output lcs_pkg::lcs_out_t out_data
);
  import lcs_pkg::*;

  localparam logic [SUB_W-1:0] SUB_OWN = SUB_W'(5);
  localparam logic [SUB_W-1:0] SUB_FIN = SUB_W'(6);
  localparam logic [SUB_W-1:0] SUB_UPD = SUB_W'(7);
  localparam logic [SUB_W-1:0] SUB_ACC = SUB_W'(8);

  logic signed [63:0] cur_mem [1 << ADDR_W];
  logic signed [63:0] nxt_mem [1 << ADDR_W];

  lcs_in_t            item_r;
  lcs_out_t           out_r;
  logic [15:0]        max_iter_r;
  logic [15:0]        iter_cnt_r;
  logic signed [63:0] last_growth_r, last_excess_r;
  logic signed [63:0] cur_q_r, nxt_q_r, rv_r;
  logic signed [63:0] gv_r, acc_r, pa_r, pb_r, own_r, fin_r, t1_r, t_r, d_r;
  logic signed [63:0] r_r, e_r, two_r_r;

  logic [ADDR_W-1:0]  item_addr, rd_addr, cur_wa;
  logic               quad, cur_we, nxt_we;
  logic signed [63:0] q, add, cur_wd, w, pmax;

  function automatic logic [ADDR_W-1:0] fold(input logic [NB-1:0] x);
    logic [NB-1:0] y;
    logic [NB-1:0] f;
    y = ~x;
    f = (x < y) ? x : y;
    return f[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] gather_addr(input logic [ADDR_W-1:0] i,
                                                    input logic [2:0] slot);
    logic [NB-1:0] s, ns, x0, y0, x;
    s  = {1'b0, i};
    ns = ~s;
    x0 = (s & ODD_M) | ((s & EVEN_M & LO_M) << 2);
    y0 = ((ns & ODD_M & HI_M) << 2) | (ns & EVEN_M);
    if (!i[ADDR_W-1]) begin
      x = {s[NB-3:0], slot[1:0]};
    end else begin
      case (slot[1:0])
        2'd0:    x = x0;
        2'd1:    x = x0 | NB'(1);
        2'd2:    x = y0;
        default: x = y0 | NB'(2);
      endcase
    end
    if (slot[2]) return i;
    return fold(x);
  endfunction

  assign item_addr = ADDR_W'(item_r.entry_index);
  assign quad      = !cmd.idx[ADDR_W-1];
  assign q         = cmd.pass2 ? nxt_q_r : cur_q_r;
  assign add       = (cmd.pass2 && !quad) ? r_r : 64'sd0;
  assign w         = ssub(t_r, fin_r);
  assign pmax      = (pa_r > pb_r) ? pa_r : pb_r;

  assign sts.op        = lcs_op_t'(item_r.operation);
  assign sts.idx_bad   = (33'(item_r.entry_index) >= DEPTH_EXT);
  assign sts.limit_hit = (iter_cnt_r >= max_iter_r);
  assign out_data      = out_r;

  always_comb begin
    rd_addr = cmd.host_rd ? item_addr : gather_addr(cmd.idx, cmd.sub[2:0]);
    cur_we  = cmd.clr_wr || cmd.host_wr || (cmd.run && cmd.pass2 && cmd.sub == SUB_ACC);
    cur_wa  = cmd.host_wr ? item_addr : cmd.idx;
    if (cmd.clr_wr) cur_wd = 64'sd0;
    else if (cmd.host_wr) cur_wd = item_r.entry_value;
    else cur_wd = ssub(t_r, two_r_r);
    nxt_we  = cmd.run && !cmd.pass2 && cmd.sub == SUB_UPD;
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    cur_q_r <= cur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[cmd.idx] <= fin_r;
    nxt_q_r <= nxt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r    <= 16'd99;
      iter_cnt_r    <= '0;
      last_growth_r <= '0;
      last_excess_r <= '0;
    end else begin
      if (cfg_valid) max_iter_r <= cfg_data;
      if (cmd.finish) begin
        last_growth_r <= r_r;
        last_excess_r <= e_r;
        iter_cnt_r    <= iter_cnt_r + 16'd1;
      end
    end
  end

  // Per-entry schedule: reads issue on sub 0..4, their data lands in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item_r <= in_data;
      rv_r   <= '0;
    end
    if (cmd.cap_rd) rv_r <= cur_q_r;
    if (cmd.start) begin
      r_r <= S_MIN;
      e_r <= '0;
    end
    if (cmd.prep) two_r_r <= sadd(r_r, r_r);
    if (cmd.run) begin
      if (cmd.sub >= SUB_W'(1) && cmd.sub <= SUB_W'(4)) gv_r <= sadd(q, add);
      if (cmd.sub == SUB_OWN) own_r <= q;
      case (cmd.sub)
        SUB_W'(2): acc_r <= gv_r;
        SUB_W'(3): begin
          if (quad) acc_r <= sadd(acc_r, gv_r);
          else pa_r <= sadd(acc_r, gv_r);
        end
        SUB_W'(4): begin
          if (quad) acc_r <= sadd(acc_r, gv_r);
          else acc_r <= gv_r;
        end
        SUB_OWN: begin
          if (quad) acc_r <= sadd(acc_r, gv_r);
          else pb_r <= sadd(acc_r, gv_r);
        end
        SUB_FIN: begin
          fin_r <= quad ? sadd(FX_ONE, acc_r >>> 2) : (pmax >>> 1);
          t1_r  <= sadd(own_r, r_r);
        end
        SUB_UPD: begin
          if (cmd.pass2) t_r <= sadd(t1_r, r_r);
          else d_r <= ssub(fin_r, own_r);
        end
        SUB_ACC: begin
          if (cmd.pass2) begin
            if (w > e_r) e_r <= w;
          end else if (d_r > r_r) begin
            r_r <= d_r;
          end
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_r.status           <= cmd.status;
      out_r.read_value       <= rv_r;
      out_r.growth_r         <= last_growth_r;
      out_r.excess_e         <= last_excess_r[62:0];
      out_r.iteration_number <= iter_cnt_r;
    end
  end

endmodule

// ----- src/lcs_checker.sv -----
// Port-level checker for the LCS value-iteration block, with its bind.
`timescale 1ns / 1ps
`include "lcs_constant_value_iteration_macros.svh"

module lcs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lcs_pkg::lcs_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lcs_pkg::lcs_out_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [15:0]       cfg_data
);
  import lcs_pkg::*;

  `LCS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `LCS_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
  `LCS_ASSERT_IMP(a_bad_idx_rv, clk, rst_n, out_valid && out_data.status == STS_BAD_IDX, out_data.read_value == 64'sd0, "read value set on bad index")
  `LCS_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_data.status != 2'd3, "undefined status code")

endmodule

bind lcs_constant_value_iteration lcs_checker u_lcs_checker (.*);

// ----- bench/lcs_constant_value_iteration_tb.sv -----
// Testbench for the LCS value-iteration engine: directed and random items, checked by a predictor.
`timescale 1ns / 1ps

module lcs_constant_value_iteration_tb;
  import lcs_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 2000000;
  localparam int DEPTH      = 32768;
  localparam longint unsigned NSTR  = 64'd65536;
  localparam longint unsigned QUART = 64'd16384;
  localparam longint unsigned HALF  = 64'd32768;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lcs_in_t   in_data;
  logic      out_valid;
  logic      out_stall;
  lcs_out_t  out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  lcs_constant_value_iteration i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Shadow state of the block.
  longint      cur_vec [DEPTH];
  longint      nxt_vec [DEPTH];
  longint      growth_q;
  longint      excess_q;
  logic [15:0] iter_count;
  logic [15:0] iter_limit;

  lcs_out_t    pending_results[$];
  int          errors;
  int          gap_max;        // upper bound of sender and receiver idle draws
  int          hold_req;       // bumped by a test to request a long receiver hold
  int          hold_seen;
  int          hold_left;
  int          rx_gap;
  int          idle_cycles;

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S_MIN : S_MAX;
    return s;
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    longint s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S_MIN : S_MAX;
    return s;
  endfunction

  // Complement-fold a string pair and fetch its entry, plus an offset.
  function automatic longint fetch_folded(bit use_next, longint unsigned x, longint add);
    longint unsigned y, f;
    y = (NSTR - 1) - x;
    f = (x < y) ? x : y;
    f = f & (HALF - 1);
    return sat_add(use_next ? nxt_vec[f] : cur_vec[f], add);
  endfunction

  function automatic longint step_entry(bit use_next, longint unsigned i, longint add);
    longint unsigned base, s1, s2, hi, lo, x0, y0;
    longint sum, pa, pb;
    if (i < QUART) begin
      // Lower quarter: 1 + sum of four gathered entries / 4.
      base = ((i & 64'hAAAAAAAA) << 2) | ((i & 64'h55555555) << 2);
      sum  = sat_add(fetch_folded(use_next, base, 0), fetch_folded(use_next, base | 1, 0));
      sum  = sat_add(sum, fetch_folded(use_next, base | 2, 0));
      sum  = sat_add(sum, fetch_folded(use_next, base | 3, 0));
      return sat_add(FX_ONE, sum >>> 2);
    end
    // Upper quarter: half the larger of two mirrored pair sums.
    s1 = i;
    hi = s1 & 64'hAAAAAAAA;
    lo = (s1 & 64'h55555555) & ((64'd1 << 14) - 1);
    x0 = hi | (lo << 2);
    pa = sat_add(fetch_folded(use_next, x0, add), fetch_folded(use_next, x0 | 1, add));
    s2 = HALF + QUART - 1 - (i - QUART);
    hi = (s2 & 64'hAAAAAAAA) & ((64'd1 << 15) - 1);
    lo = s2 & 64'h55555555;
    y0 = (hi << 2) | lo;
    pb = sat_add(fetch_folded(use_next, y0, add), fetch_folded(use_next, y0 | 2, add));
    return (pa > pb ? pa : pb) >>> 1;
  endfunction

  task automatic run_value_step();
    longint r, e, d, fp, t, two_r;
    r = S_MIN;
    e = 0;
    for (int i = 0; i < DEPTH; i++) nxt_vec[i] = step_entry(1'b0, i, 0);
    for (int i = 0; i < DEPTH; i++) begin
      d = sat_sub(nxt_vec[i], cur_vec[i]);
      if (d > r) r = d;
    end
    for (int i = 0; i < DEPTH; i++) begin
      fp = step_entry(1'b1, i, r);
      t  = sat_add(sat_add(nxt_vec[i], r), r);
      d  = sat_sub(t, fp);
      if (d > e) e = d;
    end
    two_r = sat_add(r, r);
    for (int i = 0; i < DEPTH; i++)
      cur_vec[i] = sat_sub(sat_add(sat_add(nxt_vec[i], r), r), two_r);
    growth_q   = r;
    excess_q   = e;
    iter_count = iter_count + 16'd1;
  endtask

  task automatic predict_item(lcs_in_t it);
    lcs_out_t res;
    res = '0;
    res.status = STS_OK;
    case (it.operation)
      OP_WRITE: cur_vec[it.entry_index] = it.entry_value;
      OP_READ:  res.read_value = cur_vec[it.entry_index];
      OP_ITER: begin
        if (iter_count >= iter_limit) res.status = STS_LIMIT;
        else run_value_step();
      end
      default: ;
    endcase
    res.growth_r         = growth_q;
    res.excess_e         = excess_q[62:0];
    res.iteration_number = iter_count;
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_item(lcs_in_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  function automatic lcs_in_t make_item(lcs_op_t op, int idx, longint val);
    lcs_in_t it;
    it.operation   = op;
    it.entry_index = idx[14:0];
    it.entry_value = val;
    return it;
  endfunction

  function automatic lcs_in_t random_item(bit allow_iter);
    lcs_in_t it;
    int      pick;
    pick = $urandom_range(0, 9);
    it.operation   = (pick < 5) ? OP_WRITE : (pick < 8) ? OP_READ :
                     (pick == 8 && allow_iter) ? OP_ITER : 2'd3;
    it.entry_index = 15'($urandom_range(0, 32767));
    // Mix full-range values with small fixed-point ones.
    if ($urandom_range(0, 1)) it.entry_value = {$urandom, $urandom};
    else it.entry_value = longint'($signed($urandom_range(0, 65535) - 32768)) <<< 20;
    return it;
  endfunction

  // Quiet the input, drain every result, then write the limit register.
  task automatic write_limit(logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    iter_limit = value;
  endtask

  // ---------------------------------------------------------------- receiver / checker
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    lcs_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, out_data);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.status !== exp_res.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_res.status, out_data.status);
          errors++;
        end
        if (out_data.read_value !== exp_res.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, exp_res.read_value,
                   out_data.read_value);
          errors++;
        end
        if (out_data.growth_r !== exp_res.growth_r) begin
          $display("%0t: growth_r exp %h got %h", $time, exp_res.growth_r, out_data.growth_r);
          errors++;
        end
        if (out_data.excess_e !== exp_res.excess_e) begin
          $display("%0t: excess_e exp %h got %h", $time, exp_res.excess_e, out_data.excess_e);
          errors++;
        end
        if (out_data.iteration_number !== exp_res.iteration_number) begin
          $display("%0t: iteration_number exp %0d got %0d", $time,
                   exp_res.iteration_number, out_data.iteration_number);
          errors++;
        end
      end
      rx_gap = $urandom_range(0, gap_max);
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
    end
    out_stall <= (rx_gap > 0) || (hold_left > 0);
  end

  // Watchdog: any transfer on any channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // Extremes of index and value, every operation, and an iterate at limit 0.
  task automatic test_directed_access();
    write_limit(16'd0);
    send_item(make_item(OP_WRITE, 0, S_MAX));
    send_item(make_item(OP_WRITE, 32767, S_MIN));
    send_item(make_item(OP_WRITE, 21845, 64'sh5555_5555_5555_5555));
    send_item(make_item(OP_WRITE, 10922, 64'shAAAA_AAAA_AAAA_AAAA));
    send_item(make_item(OP_READ, 0, 0));
    send_item(make_item(OP_READ, 32767, 0));
    send_item(make_item(OP_READ, 21845, 0));
    send_item(make_item(OP_READ, 10922, 0));
    send_item(make_item(OP_READ, 1, 0));
    send_item(make_item(lcs_op_t'(2'd3), 32767, S_MAX));   // unused opcode
    send_item(make_item(OP_ITER, 0, 0));                    // limit reached
    send_item(make_item(OP_READ, 0, 0));
  endtask

  // One real iteration over a vector holding saturating and ordinary entries.
  task automatic test_single_iteration();
    write_limit(16'd1);
    send_item(make_item(OP_WRITE, 5, FX_ONE));
    send_item(make_item(OP_WRITE, 16384, -FX_ONE));
    send_item(make_item(OP_ITER, 0, 0));
    send_item(make_item(OP_READ, 0, 0));
    send_item(make_item(OP_READ, 16384, 0));
    send_item(make_item(OP_READ, 32767, 0));
    send_item(make_item(OP_ITER, 0, 0));                    // limit reached again
  endtask

  // Random accesses at the top limit, with a long receiver hold-off.
  task automatic test_random_access();
    write_limit(16'hFFFF);
    for (int n = 0; n < 45; n++) begin
      if (n == 10) hold_req++;
      gap_max = (n >= 25 && n < 35) ? 0 : 11;
      send_item(random_item(1'b0));
    end
    gap_max = 11;
  endtask

  // Second real iteration, then random traffic with iterates held at the limit.
  task automatic test_second_iteration();
    write_limit(16'd2);
    send_item(make_item(OP_ITER, 0, 0));
    for (int n = 0; n < 45; n++) send_item(random_item(1'b1));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors    = 0;
    gap_max   = 11;
    hold_req  = 0;
    hold_seen = 0;
    hold_left = 0;
    rx_gap    = 0;
    idle_cycles = 0;
    for (int i = 0; i < DEPTH; i++) cur_vec[i] = 0;
    growth_q   = 0;
    excess_q   = 0;
    iter_count = 0;
    iter_limit = 16'd99;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_access();
    test_single_iteration();
    test_random_access();
    test_second_iteration();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
